[design/slf_pkg.sv]
package slf_pkg;

    localparam int NUM_KEYS_DEF = 4096;
    localparam int OUT_DIM_DEF  = 8;
    localparam int NORM_WORDS   = 4;
    localparam int KEY_W        = 12;
    localparam int SUM_W        = KEY_W + 1;

    localparam logic signed [31:0] ONE_Q16     = 32'sh0001_0000;
    localparam logic signed [31:0] MINUS_ONE_Q = -32'sh0001_0000;

    // input item kinds
    localparam logic [1:0] KIND_LOAD    = 2'd0;
    localparam logic [1:0] KIND_BIAS    = 2'd1;
    localparam logic [1:0] KIND_FEATURE = 2'd2;
    localparam logic [1:0] KIND_READ    = 2'd3;

    // result item kinds
    localparam logic [1:0] OUT_NORM = 2'd0;
    localparam logic [1:0] OUT_ELEM = 2'd1;
    localparam logic [1:0] OUT_READ = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_KEY_OFFSET = 2'd0;
    localparam logic [1:0] CFG_MAX_NORM   = 2'd1;
    localparam logic [1:0] CFG_TRAIN      = 2'd2;

    typedef struct packed {
        logic [1:0]         kind;
        logic [11:0]        key;
        logic [3:0]         column;
        logic signed [31:0] data_word;
        logic               last_in_example;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         out_kind;
        logic [3:0]         out_index;
        logic signed [31:0] out_data;
        logic               out_last;
    } out_item_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_KEY0,
        ST_KEY1,
        ST_KEY2,
        ST_LOAD,
        ST_RD_ISSUE,
        ST_RD_WAIT,
        ST_N_RD0,
        ST_N_RD1,
        ST_N_RD3,
        ST_N_CAP,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_WR0,
        ST_WR1,
        ST_WR2,
        ST_N_MUL,
        ST_N_ADD,
        ST_N_EMIT,
        ST_ACC
    } state_t;

endpackage

[design/slf_ram.sv]
module slf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[design/slf_recip.sv]
// Restoring divider for floor(2^32 / divisor), one quotient bit a cycle,
// saturated to 0x7FFFFFFF (a zero divisor saturates too).
module slf_recip (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [30:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);

    localparam int STEPS = 33;

    logic [32:0] rem_reg, rem_next;
    logic [32:0] quo_reg, quo_next;
    logic [30:0] div_reg;
    logic [5:0]  cnt_reg, cnt_next;
    logic        run_reg, run_next;
    logic        done_reg, done_next;
    logic [32:0] shifted;
    logic        qbit;

    always_comb
    begin
        shifted  = {rem_reg[31:0], (cnt_reg == 6'(STEPS))};
        qbit     = shifted >= {2'b00, div_reg};
        rem_next = rem_reg;
        quo_next = quo_reg;
        cnt_next = cnt_reg;
        run_next = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = '0;
            quo_next = '0;
            cnt_next = 6'(STEPS);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            rem_next = qbit ? shifted - {2'b00, div_reg} : shifted;
            quo_next = {quo_reg[31:0], qbit};
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            div_reg <= divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = (quo_reg[32] || quo_reg[31:0] >= 32'h7FFF_FFFF) ? 32'h7FFF_FFFF
                                                                       : quo_reg[31:0];

endmodule

[design/sparse_index_linear_forward.sv]
// A bias item is written on acceptance; load and read items map the key first, and a read
// result is registered. A feature item runs the OUT_DIM MAC, with max-normalize when enabled,
// table writes in train mode and a reciprocal divide when training raises the stored max (33-step divider).
// Weights stream through one table port, one a cycle; a full result register stalls it on an example's last feature.
// One item is processed at a time; a waiting result does not block acceptance.
// Reset (rst_n, async, low) clears config, example flag and handshake state, not memories.
module sparse_index_linear_forward #(
    parameter int NUM_KEYS = slf_pkg::NUM_KEYS_DEF,
    parameter int OUT_DIM  = slf_pkg::OUT_DIM_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  slf_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output slf_pkg::out_item_t out_item,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [11:0]        cfg_data
);

    localparam int ROW_WORDS = slf_pkg::NORM_WORDS + OUT_DIM;
    localparam int DEPTH     = NUM_KEYS * ROW_WORDS;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int ROW_W     = $clog2(NUM_KEYS);
    localparam int AUX_DEPTH = 2 * OUT_DIM;
    localparam int AUX_AW    = $clog2(AUX_DEPTH);
    localparam int KW        = (OUT_DIM > 1) ? $clog2(OUT_DIM) : 1;
    localparam int CW        = $clog2(OUT_DIM + 1);
    localparam int RCP_SH    = 26;
    localparam int RECIP     = (1 << RCP_SH) / NUM_KEYS;
    localparam int MP_W      = slf_pkg::SUM_W + 23;

    function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
        if (v > 49'sh0_0000_7FFF_FFFF)
            return 32'sh7FFF_FFFF;
        else if (v < -49'sh0_0000_8000_0000)
            return 32'sh8000_0000;
        else
            return v[31:0];
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [48:0] v);
        if (v[48] != v[47])
            return v[48] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
        else
            return v[47:0];
    endfunction

    slf_pkg::state_t state_reg, state_next;

    // configuration
    logic [11:0] key_offset_reg;
    logic        max_norm_reg;
    logic        train_reg;
    logic        in_example_reg, in_example_next;

    // latched item and datapath
    slf_pkg::in_item_t item_reg;
    logic [slf_pkg::SUM_W-1:0] sum_reg;
    logic [MP_W-1:0]           mprod_reg;
    logic [ROW_W-1:0]          row_reg;
    logic [ADDR_W-1:0]         base_reg;
    logic [31:0]               abs_reg;
    logic signed [31:0]        w0_reg, w1_reg, w3_reg;
    logic                      gt_reg;
    logic signed [63:0]        nprod_reg;
    logic signed [31:0]        val_reg;

    // MAC pipeline
    logic [CW-1:0]      issue_cnt_reg;
    logic               p1_valid_reg, p2_valid_reg;
    logic [KW-1:0]      p1_k_reg, p2_k_reg;
    logic signed [63:0] p2_prod_reg;
    logic signed [47:0] p2_acc_reg;
    logic               advance, issue, acc_done;
    logic [KW-1:0]      k_sel;
    logic signed [48:0] acc_sum;
    logic signed [47:0] acc_new;

    // memories
    logic              tbl_we;
    logic [ADDR_W-1:0] tbl_waddr, tbl_raddr;
    logic [31:0]       tbl_wdata, tbl_rdata;
    logic              aux_we;
    logic [AUX_AW-1:0] aux_waddr, aux_raddr;
    logic [47:0]       aux_wdata, aux_rdata;

    // divider
    logic        div_start, div_done;
    logic [31:0] div_q;

    // output register
    slf_pkg::out_item_t out_reg, out_load_item;
    logic               out_valid_reg, out_load, out_free;

    logic accept, col_ok, gt_now;
    logic [31:0] rem_full;
    logic [9:0]  quot;
    logic signed [48:0] nval;

    assign accept    = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || out_ready;
    assign col_ok    = 32'(item_reg.column) < ROW_WORDS;
    assign gt_now    = $signed(abs_reg) > w0_reg;

    assign advance  = !(p2_valid_reg && item_reg.last_in_example && !out_free);
    assign issue    = advance && (32'(issue_cnt_reg) < OUT_DIM);
    assign acc_done = (32'(issue_cnt_reg) == OUT_DIM) && !p1_valid_reg && !p2_valid_reg;
    // on a stall the read port re-reads the entry held in stage 1
    assign k_sel    = advance ? issue_cnt_reg[KW-1:0] : p1_k_reg;

    assign acc_sum = {p2_acc_reg[47], p2_acc_reg} + 49'($signed(p2_prod_reg[63:16]));
    assign acc_new = sat48(acc_sum);

    assign quot     = mprod_reg[RCP_SH +: 10];
    assign rem_full = 32'(sum_reg) - 32'(quot) * 32'(NUM_KEYS);

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            slf_pkg::ST_IDLE:
            begin
                if (accept && in_item.kind != slf_pkg::KIND_BIAS)
                    state_next = slf_pkg::ST_KEY0;
            end
            slf_pkg::ST_KEY0: state_next = slf_pkg::ST_KEY1;
            slf_pkg::ST_KEY1: state_next = slf_pkg::ST_KEY2;
            slf_pkg::ST_KEY2:
            begin
                case (item_reg.kind)
                    slf_pkg::KIND_LOAD: state_next = slf_pkg::ST_LOAD;
                    slf_pkg::KIND_READ: state_next = slf_pkg::ST_RD_ISSUE;
                    default:
                        state_next = max_norm_reg ? slf_pkg::ST_N_RD0 : slf_pkg::ST_ACC;
                endcase
            end
            slf_pkg::ST_LOAD:     state_next = slf_pkg::ST_IDLE;
            slf_pkg::ST_RD_ISSUE: state_next = slf_pkg::ST_RD_WAIT;
            slf_pkg::ST_RD_WAIT:
            begin
                if (out_free)
                    state_next = slf_pkg::ST_IDLE;
            end
            slf_pkg::ST_N_RD0: state_next = slf_pkg::ST_N_RD1;
            slf_pkg::ST_N_RD1: state_next = slf_pkg::ST_N_RD3;
            slf_pkg::ST_N_RD3: state_next = slf_pkg::ST_N_CAP;
            slf_pkg::ST_N_CAP:
            begin
                if (!train_reg)
                    state_next = slf_pkg::ST_N_MUL;
                else if (gt_now)
                    state_next = slf_pkg::ST_DIV_GO;
                else
                    state_next = slf_pkg::ST_WR2;
            end
            slf_pkg::ST_DIV_GO: state_next = slf_pkg::ST_DIV_WAIT;
            slf_pkg::ST_DIV_WAIT:
            begin
                if (div_done)
                    state_next = slf_pkg::ST_WR0;
            end
            slf_pkg::ST_WR0:  state_next = slf_pkg::ST_WR1;
            slf_pkg::ST_WR1:  state_next = slf_pkg::ST_WR2;
            slf_pkg::ST_WR2:  state_next = slf_pkg::ST_N_MUL;
            slf_pkg::ST_N_MUL: state_next = slf_pkg::ST_N_ADD;
            slf_pkg::ST_N_ADD: state_next = slf_pkg::ST_N_EMIT;
            slf_pkg::ST_N_EMIT:
            begin
                if (out_free)
                    state_next = slf_pkg::ST_ACC;
            end
            slf_pkg::ST_ACC:
            begin
                if (acc_done)
                    state_next = slf_pkg::ST_IDLE;
            end
            default: state_next = slf_pkg::ST_IDLE;
        endcase
    end

    // ---------------- outputs / port control ----------------
    always_comb
    begin
        in_ready      = (state_reg == slf_pkg::ST_IDLE);
        tbl_we        = 1'b0;
        tbl_waddr     = base_reg;
        tbl_wdata     = item_reg.data_word;
        tbl_raddr     = base_reg;
        aux_we        = 1'b0;
        aux_waddr     = AUX_AW'(in_item.column);
        aux_wdata     = 48'(in_item.data_word);
        aux_raddr     = in_example_reg ? AUX_AW'(OUT_DIM) + AUX_AW'(k_sel) : AUX_AW'(k_sel);
        div_start     = 1'b0;
        out_load      = 1'b0;
        out_load_item = '0;
        in_example_next = in_example_reg;
        case (state_reg)
            slf_pkg::ST_IDLE:
            begin
                if (accept && in_item.kind == slf_pkg::KIND_BIAS
                    && 32'(in_item.column) < OUT_DIM)
                    aux_we = 1'b1;
            end
            slf_pkg::ST_LOAD:
            begin
                tbl_we    = col_ok;
                tbl_waddr = base_reg + ADDR_W'(item_reg.column);
            end
            slf_pkg::ST_RD_ISSUE:
            begin
                tbl_raddr = base_reg + ADDR_W'(item_reg.column);
            end
            slf_pkg::ST_RD_WAIT:
            begin
                tbl_raddr = base_reg + ADDR_W'(item_reg.column);
                out_load  = out_free;
                out_load_item.out_kind  = slf_pkg::OUT_READ;
                out_load_item.out_index = item_reg.column;
                out_load_item.out_data  = col_ok ? $signed(tbl_rdata) : 32'sd0;
                out_load_item.out_last  = 1'b1;
            end
            slf_pkg::ST_N_RD0: tbl_raddr = base_reg;
            slf_pkg::ST_N_RD1: tbl_raddr = base_reg + ADDR_W'(1);
            slf_pkg::ST_N_RD3: tbl_raddr = base_reg + ADDR_W'(3);
            slf_pkg::ST_DIV_GO: div_start = 1'b1;
            slf_pkg::ST_WR0:
            begin
                tbl_we    = 1'b1;
                tbl_wdata = abs_reg;
            end
            slf_pkg::ST_WR1:
            begin
                tbl_we    = 1'b1;
                tbl_waddr = base_reg + ADDR_W'(1);
                tbl_wdata = w1_reg;
            end
            slf_pkg::ST_WR2:
            begin
                tbl_we    = 1'b1;
                tbl_waddr = base_reg + ADDR_W'(2);
                tbl_wdata = slf_pkg::ONE_Q16;
            end
            slf_pkg::ST_N_EMIT:
            begin
                out_load = out_free;
                out_load_item.out_kind  = slf_pkg::OUT_NORM;
                out_load_item.out_index = 4'd0;
                out_load_item.out_data  = val_reg;
                out_load_item.out_last  = !item_reg.last_in_example;
            end
            slf_pkg::ST_ACC:
            begin
                tbl_raddr = base_reg + ADDR_W'(slf_pkg::NORM_WORDS) + ADDR_W'(k_sel);
                aux_we    = p2_valid_reg && advance;
                aux_waddr = AUX_AW'(OUT_DIM) + AUX_AW'(p2_k_reg);
                aux_wdata = acc_new;
                out_load  = p2_valid_reg && item_reg.last_in_example && out_free;
                out_load_item.out_kind  = slf_pkg::OUT_ELEM;
                out_load_item.out_index = 4'(p2_k_reg);
                out_load_item.out_data  = sat32({acc_new[47], acc_new});
                out_load_item.out_last  = (32'(p2_k_reg) == OUT_DIM - 1);
                if (acc_done)
                    in_example_next = !item_reg.last_in_example;
            end
            default: ;
        endcase
    end

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= slf_pkg::ST_IDLE;
            key_offset_reg <= '0;
            max_norm_reg   <= 1'b0;
            train_reg      <= 1'b0;
            in_example_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            p1_valid_reg   <= 1'b0;
            p2_valid_reg   <= 1'b0;
            issue_cnt_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            in_example_reg <= in_example_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    slf_pkg::CFG_KEY_OFFSET: key_offset_reg <= cfg_data;
                    slf_pkg::CFG_MAX_NORM:   max_norm_reg   <= cfg_data[0];
                    slf_pkg::CFG_TRAIN:      train_reg      <= cfg_data[0];
                    default: ;
                endcase
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (state_reg == slf_pkg::ST_KEY2)
            begin
                issue_cnt_reg <= '0;
                p1_valid_reg  <= 1'b0;
                p2_valid_reg  <= 1'b0;
            end
            else if (state_reg == slf_pkg::ST_ACC && advance)
            begin
                if (issue)
                    issue_cnt_reg <= issue_cnt_reg + CW'(1);
                p1_valid_reg <= issue;
                p2_valid_reg <= p1_valid_reg;
            end
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge clk)
    begin
        if (out_load)
            out_reg <= out_load_item;
        if (accept)
        begin
            item_reg <= in_item;
            sum_reg  <= (in_item.kind == slf_pkg::KIND_FEATURE)
                        ? slf_pkg::SUM_W'(in_item.key) + slf_pkg::SUM_W'(key_offset_reg)
                        : slf_pkg::SUM_W'(in_item.key);
            if (in_item.data_word == 32'sh8000_0000)
                abs_reg <= 32'h7FFF_FFFF;
            else if (in_item.data_word[31])
                abs_reg <= 32'(-in_item.data_word);
            else
                abs_reg <= in_item.data_word;
        end
        case (state_reg)
            slf_pkg::ST_KEY0: mprod_reg <= MP_W'(sum_reg) * MP_W'(RECIP);
            slf_pkg::ST_KEY1:
                row_reg <= (rem_full >= 32'(NUM_KEYS)) ? ROW_W'(rem_full - 32'(NUM_KEYS))
                                                       : ROW_W'(rem_full);
            slf_pkg::ST_KEY2:
            begin
                base_reg <= ADDR_W'(32'(row_reg) * 32'(ROW_WORDS));
                val_reg  <= item_reg.data_word;
            end
            slf_pkg::ST_N_RD1: w0_reg <= tbl_rdata;
            slf_pkg::ST_N_RD3: w1_reg <= tbl_rdata;
            slf_pkg::ST_N_CAP:
            begin
                w3_reg <= tbl_rdata;
                gt_reg <= gt_now;
            end
            slf_pkg::ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    w1_reg <= div_q;
                    w0_reg <= abs_reg;
                    gt_reg <= 1'b0;
                end
            end
            slf_pkg::ST_N_MUL: nprod_reg <= item_reg.data_word * w1_reg;
            slf_pkg::ST_N_ADD: val_reg <= sat32(nval);
            slf_pkg::ST_ACC:
            begin
                if (advance)
                begin
                    p1_k_reg    <= issue_cnt_reg[KW-1:0];
                    p2_k_reg    <= p1_k_reg;
                    p2_prod_reg <= $signed(tbl_rdata) * val_reg;
                    p2_acc_reg  <= aux_rdata;
                end
            end
            default: ;
        endcase
    end

    always_comb
    begin
        if (gt_reg)
        begin
            if (item_reg.data_word < 0)
                nval = 49'(slf_pkg::MINUS_ONE_Q);
            else if (item_reg.data_word > 0)
                nval = 49'(slf_pkg::ONE_Q16);
            else
                nval = '0;
        end
        else
        begin
            nval = 49'($signed(nprod_reg[63:16]));
        end
        nval = nval + 49'(w3_reg);
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    slf_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    // biases at 0..OUT_DIM-1, accumulators above them
    slf_ram #(.WIDTH(48), .DEPTH(AUX_DEPTH)) u_aux (
        .clk   (clk),
        .we    (aux_we),
        .waddr (aux_waddr),
        .wdata (aux_wdata),
        .raddr (aux_raddr),
        .rdata (aux_rdata)
    );

    slf_recip u_recip (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .divisor  (abs_reg[30:0]),
        .done     (div_done),
        .quotient (div_q)
    );

endmodule

[design/slf_checker.sv]
module slf_props (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input slf_pkg::out_item_t out_item
);

    // a held item must not change
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("result item changed while stalled");

    a_out_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_item.out_kind == slf_pkg::OUT_NORM
                       || out_item.out_kind == slf_pkg::OUT_ELEM
                       || out_item.out_kind == slf_pkg::OUT_READ))
        else $error("bad result kind");

    a_read_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.out_kind == slf_pkg::OUT_READ |-> out_item.out_last)
        else $error("read result not marked last");

    a_norm_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.out_kind == slf_pkg::OUT_NORM |-> out_item.out_index == 4'd0)
        else $error("normalised value with non-zero index");

endmodule

bind sparse_index_linear_forward slf_props u_slf_props (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
);
